FILE: sv/dictionary_rle_palette_decoder_macros.svh
// Assertion macros for the dictionary RLE palette decoder.
// Included by the top level; defining NO_ASSERTIONS leaves them empty.
`ifndef DICTIONARY_RLE_PALETTE_DECODER_MACROS_SVH
`define DICTIONARY_RLE_PALETTE_DECODER_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property that must hold at every edge outside reset.
`define DRPD_ASSERT_ALWAYS(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("drpd assertion failed");
// Implication from one cycle to the next.
`define DRPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("drpd assertion failed");
`else
`define DRPD_ASSERT_ALWAYS(label, clk, rst, prop)
`define DRPD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: sv/drpd_pkg.sv
// Shared types and constants for the dictionary RLE palette decoder.
// No dependencies.
package drpd_pkg;

  // Command codes passed from the front queue to the engine.
  localparam logic [1:0] OP_PIXEL = 2'd0;
  localparam logic [1:0] OP_DICT  = 2'd1;
  localparam logic [1:0] OP_PAL   = 2'd2;

  // Input kind codes.
  localparam logic [1:0] KIND_PIXEL = 2'd0;
  localparam logic [1:0] KIND_DICT  = 2'd1;
  localparam logic [1:0] KIND_PAL   = 2'd2;

  // Byte codes of the stream.
  localparam logic [7:0] CODE_FIRST  = 8'hD0;
  localparam logic [7:0] CODE_END    = 8'hFF;
  localparam logic [6:0] ALPHA_INDEX = 7'h0F;

  // Results kept per picture word.
  localparam logic [5:0] MAX_RESULTS = 6'd32;

  typedef struct packed {
    logic [1:0]  op;
    logic [6:0]  idx;
    logic [15:0] value;
  } cmd_t;

  typedef struct packed {
    logic [15:0] color;
    logic [7:0]  run_length;
    logic        picture_end;
    logic        nest_error;
    logic        last;
  } res_t;

endpackage

FILE: sv/dictionary_rle_palette_decoder.sv
// Dictionary RLE palette decoder. A picture word is started, then each
// leaf byte that gives a run is looked up in the palette, run start bytes
// and end markers are consumed, dictionary codes are expanded, and the word
// is closed; dictionary and palette writes are taken while idle. A full
// result queue stalls the engine for as long as it stays full. The pacing is
// set by the single expansion stack and the registered reads of the dictionary
// and palette memories. A two-entry command queue and a two-entry result queue
// let input and output stall independently of the engine.
`include "dictionary_rle_palette_decoder_macros.svh"
module dictionary_rle_palette_decoder import drpd_pkg::*; #(
  parameter int DICT_ENTRIES = 47,
  parameter int PALETTE_SIZE = 128,
  parameter int MAX_NEST     = 5
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  kind,
  input  logic [6:0]  entry_index,
  input  logic [15:0] value,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] color,
  output logic [7:0]  run_length,
  output logic        picture_end,
  output logic        nest_error,
  output logic        last,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_data
);

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;
  logic res_push;
  res_t res_data;
  logic res_full;
  res_t head;

  // Front end.
  drpd_cmdq u_cmdq (
    .clk, .rst, .push, .full, .kind, .entry_index, .value,
    .cmd_valid, .cmd, .cmd_pop
  );

  // Back end.
  drpd_engine #(
    .DICT_ENTRIES(DICT_ENTRIES),
    .PALETTE_SIZE(PALETTE_SIZE),
    .MAX_NEST(MAX_NEST)
  ) u_engine (
    .clk, .rst, .cmd_valid, .cmd, .cmd_pop, .cfg_we, .cfg_data,
    .res_push, .res_data, .res_full
  );

  // Output queue.
  drpd_resq u_resq (
    .clk, .rst, .res_push, .res_data, .res_full, .pop, .empty, .head
  );

  assign color = head.color;
  assign run_length = head.run_length;
  assign picture_end = head.picture_end;
  assign nest_error = head.nest_error;
  assign last = head.last;

  // End and error results carry no pixels and close their word.
  `DRPD_ASSERT_ALWAYS(a_flag_excl, clk, rst, !(!empty && picture_end && nest_error))
  `DRPD_ASSERT_ALWAYS(a_flag_zero, clk, rst,
    !(!empty && (picture_end || nest_error)) || (run_length == 8'd0 && color == 16'd0))
  `DRPD_ASSERT_ALWAYS(a_run_nonzero, clk, rst,
    !(!empty && !picture_end && !nest_error) || (run_length != 8'd0))
  `DRPD_ASSERT_NEXT(a_stall_hold, clk, rst, !empty && !pop, !empty && $stable(run_length))

endmodule

FILE: sv/drpd_cmdq.sv
// Front end: classifies input words and queues commands for the engine.
// Depends on drpd_pkg.
module drpd_cmdq import drpd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  kind,
  input  logic [6:0]  entry_index,
  input  logic [15:0] value,
  output logic        cmd_valid,
  output cmd_t        cmd,
  input  logic        cmd_pop
);

  cmd_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       known;
  logic       wr_en;
  logic       rd_en;

  // Unknown kinds are accepted and dropped here.
  assign known = (kind == KIND_PIXEL) || (kind == KIND_DICT) || (kind == KIND_PAL);
  assign full = (count == 2'd2);
  assign wr_en = push && !full && known;
  assign rd_en = cmd_pop && (count != 2'd0);
  assign cmd_valid = (count != 2'd0);
  assign cmd = slot[rd_ptr];

  // Storage of the two entries.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot[wr_ptr].op <= kind;
      slot[wr_ptr].idx <= entry_index;
      slot[wr_ptr].value <= value;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr_en) wr_ptr <= ~wr_ptr;
      if (rd_en) rd_ptr <= ~rd_ptr;
      if (wr_en && !rd_en) count <= count + 2'd1;
      else if (!wr_en && rd_en) count <= count - 2'd1;
    end
  end

endmodule

FILE: sv/drpd_resq.sv
// Result queue between the engine and the output port.
// Depends on drpd_pkg.
module drpd_resq import drpd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic res_push,
  input  res_t res_data,
  output logic res_full,
  input  logic pop,
  output logic empty,
  output res_t head
);

  res_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       wr_en;
  logic       rd_en;

  assign res_full = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign wr_en = res_push && !res_full;
  assign rd_en = pop && !empty;
  assign head = slot[rd_ptr];

  // Storage of the two entries.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot[wr_ptr] <= res_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr_en) wr_ptr <= ~wr_ptr;
      if (rd_en) rd_ptr <= ~rd_ptr;
      if (wr_en && !rd_en) count <= count + 2'd1;
      else if (!wr_en && rd_en) count <= count - 2'd1;
    end
  end

endmodule

FILE: sv/drpd_engine.sv
// Back end: dictionary expansion stack, run decoder and palette lookup.
// Depends on drpd_pkg.
module drpd_engine import drpd_pkg::*; #(
  parameter int DICT_ENTRIES = 47,
  parameter int PALETTE_SIZE = 128,
  parameter int MAX_NEST     = 5
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  input  cmd_t       cmd,
  output logic       cmd_pop,
  input  logic       cfg_we,
  input  logic [6:0] cfg_data,
  output logic       res_push,
  output res_t       res_data,
  input  logic       res_full
);

  localparam int STACK_DEPTH = MAX_NEST + 1;
  localparam int SP_W = $clog2(STACK_DEPTH + 1);
  localparam int SI_W = $clog2(STACK_DEPTH);
  localparam int LV_W = $clog2(MAX_NEST + 1);
  localparam int DA_W = (DICT_ENTRIES > 1) ? $clog2(DICT_ENTRIES) : 1;
  localparam int PA_W = $clog2(PALETTE_SIZE);
  localparam logic [7:0] DICT_LIM = 8'(DICT_ENTRIES);
  localparam logic [7:0] PAL_LIM = 8'(PALETTE_SIZE);
  localparam logic [LV_W-1:0] NEST_LIM = LV_W'(MAX_NEST);
  localparam logic [SP_W-1:0] SP_NEST = SP_W'(MAX_NEST);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_POP    = 2'd1;
  localparam logic [1:0] ST_EXPAND = 2'd2;
  localparam logic [1:0] ST_LOOKUP = 2'd3;

  logic [1:0]      state;
  logic [SP_W-1:0] sp;
  logic [7:0]      stk_byte [STACK_DEPTH];
  logic [LV_W-1:0] stk_lvl [STACK_DEPTH];
  logic [LV_W-1:0] exp_lvl;
  logic            exp_oob;
  logic            run_pending;
  logic [6:0]      pending_index;
  logic [6:0]      alpha;
  logic            held_valid;
  res_t            held;
  logic [5:0]      n_res;
  logic [7:0]      look_len;
  logic            look_oob;

  logic [15:0] dict_mem [DICT_ENTRIES];
  logic [15:0] pal_mem [PALETTE_SIZE];
  logic [15:0] dict_rd;
  logic [15:0] pal_rd;

  logic [SP_W-1:0] sp_dec;
  logic [SI_W-1:0] top_idx;
  logic [7:0]      top_byte;
  logic [LV_W-1:0] top_lvl;
  logic [7:0]      code_e;
  logic            is_code;
  logic            can_emit;
  logic            emit_fire;
  res_t            emit_res;
  logic            flush_fire;
  logic            keep;
  logic            dict_re;
  logic            pal_re;
  logic [6:0]      pal_idx;
  logic [SI_W-1:0] push_lo;
  logic [SI_W-1:0] push_hi;

  // Transparent index substitution.
  function automatic logic [6:0] map_index(input logic [6:0] idx, input logic [6:0] alt);
    map_index = (idx == ALPHA_INDEX) ? alt : idx;
  endfunction

  // Top of the expansion stack.
  assign sp_dec = sp - SP_W'(1);
  assign top_idx = sp_dec[SI_W-1:0];
  assign top_byte = stk_byte[top_idx];
  assign top_lvl = stk_lvl[top_idx];
  assign code_e = top_byte - CODE_FIRST;
  assign is_code = (top_byte >= CODE_FIRST) && (top_byte != CODE_END);
  assign push_lo = sp[SI_W-1:0];
  assign push_hi = SI_W'(sp + SP_W'(1));

  // A new result may be taken when the held one can move on.
  assign can_emit = !held_valid || !res_full;
  assign keep = (n_res < MAX_RESULTS);

  // Step decode: command pops, result emission and memory reads.
  always_comb begin
    emit_fire = 1'b0;
    emit_res = '0;
    flush_fire = 1'b0;
    dict_re = 1'b0;
    pal_re = 1'b0;
    pal_idx = map_index(top_byte[6:0], alpha);
    cmd_pop = 1'b0;
    case (state)
      ST_IDLE: begin
        cmd_pop = cmd_valid;
      end
      ST_POP: begin
        if (sp == '0) begin
          flush_fire = held_valid && !res_full;
        end else if (is_code) begin
          if (top_lvl >= NEST_LIM || sp_dec >= SP_NEST) begin
            emit_fire = can_emit;
            emit_res.nest_error = 1'b1;
          end else begin
            dict_re = 1'b1;
          end
        end else if (top_byte == CODE_END) begin
          emit_fire = can_emit;
          emit_res.picture_end = 1'b1;
        end else if (run_pending) begin
          pal_re = 1'b1;
          pal_idx = map_index(pending_index, alpha);
        end else if (!top_byte[7]) begin
          pal_re = 1'b1;
        end
      end
      ST_LOOKUP: begin
        emit_fire = can_emit;
        emit_res.color = look_oob ? 16'd0 : pal_rd;
        emit_res.run_length = look_len;
      end
      default: begin
      end
    endcase
  end

  // Results leave in order; the final one of a word gets its last flag at flush.
  always_comb begin
    res_push = flush_fire || (emit_fire && keep && held_valid);
    res_data = held;
    res_data.last = flush_fire;
  end

  // Dictionary memory.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && cmd_valid && cmd.op == OP_DICT &&
        {1'b0, cmd.idx} < DICT_LIM) begin
      dict_mem[cmd.idx[DA_W-1:0]] <= cmd.value;
    end
    if (dict_re) begin
      dict_rd <= dict_mem[code_e[DA_W-1:0]];
    end
  end

  // Palette memory.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && cmd_valid && cmd.op == OP_PAL &&
        {1'b0, cmd.idx} < PAL_LIM) begin
      pal_mem[cmd.idx[PA_W-1:0]] <= cmd.value;
    end
    if (pal_re) begin
      pal_rd <= pal_mem[pal_idx[PA_W-1:0]];
    end
  end

  // Stack payload and lookup operands.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && cmd_valid && cmd.op == OP_PIXEL) begin
      stk_byte[0] <= cmd.value[7:0];
      stk_lvl[0] <= '0;
    end
    if (state == ST_EXPAND) begin
      stk_byte[push_lo] <= exp_oob ? 8'd0 : dict_rd[7:0];
      stk_lvl[push_lo] <= exp_lvl;
      stk_byte[push_hi] <= exp_oob ? 8'd0 : dict_rd[15:8];
      stk_lvl[push_hi] <= exp_lvl;
    end
    if (dict_re) begin
      exp_lvl <= top_lvl + LV_W'(1);
      exp_oob <= (code_e >= DICT_LIM);
    end
    if (pal_re) begin
      look_len <= run_pending ? top_byte + 8'd2 : 8'd1;
      look_oob <= ({1'b0, pal_idx} >= PAL_LIM);
    end
    if (emit_fire && keep) begin
      held <= emit_res;
    end
  end

  // Sequencer and control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      sp <= '0;
      run_pending <= 1'b0;
      pending_index <= '0;
      alpha <= '0;
      held_valid <= 1'b0;
      n_res <= '0;
    end else begin
      if (cfg_we) alpha <= cfg_data;
      if (emit_fire && keep) begin
        held_valid <= 1'b1;
        n_res <= n_res + 6'd1;
      end
      case (state)
        ST_IDLE: begin
          if (cmd_valid && cmd.op == OP_PIXEL) begin
            sp <= SP_W'(1);
            n_res <= '0;
            state <= ST_POP;
          end
        end
        ST_POP: begin
          if (sp == '0) begin
            if (!held_valid) begin
              state <= ST_IDLE;
            end else if (flush_fire) begin
              held_valid <= 1'b0;
              state <= ST_IDLE;
            end
          end else if (is_code) begin
            if (dict_re) begin
              sp <= sp_dec;
              state <= ST_EXPAND;
            end else if (emit_fire) begin
              sp <= '0;
            end
          end else if (top_byte == CODE_END) begin
            if (emit_fire) begin
              run_pending <= 1'b0;
              sp <= '0;
            end
          end else if (run_pending) begin
            run_pending <= 1'b0;
            sp <= sp_dec;
            state <= ST_LOOKUP;
          end else if (top_byte[7]) begin
            pending_index <= top_byte[6:0];
            run_pending <= 1'b1;
            sp <= sp_dec;
          end else begin
            sp <= sp_dec;
            state <= ST_LOOKUP;
          end
        end
        ST_EXPAND: begin
          sp <= sp + SP_W'(2);
          state <= ST_POP;
        end
        ST_LOOKUP: begin
          if (emit_fire) state <= ST_POP;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the dictionary RLE palette decoder.
// Depends on drpd_pkg and the dictionary_rle_palette_decoder top level.
module testbench;
  import drpd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] KIND_NONE  = 2'd3;
  localparam int         DICT_SIZE  = 47;
  localparam int         PAL_SIZE   = 128;
  localparam int         NEST_LIMIT = 5;
  localparam int         STACK_SIZE = NEST_LIMIT + 1;
  localparam logic [7:0] RUN_FLAG   = 8'h80;
  localparam int         SETTLE     = 400;
  // Random leaf bytes and codes only name these low palette and dictionary entries.
  localparam int         PAL_USED   = 32;
  localparam int         DICT_USED  = 8;

  // Scoreboard: mirrors the decoder state and keeps the expected results.
  class run_scoreboard;
    logic [15:0] dict_mem [DICT_SIZE];
    logic [15:0] pal_mem [PAL_SIZE];
    logic [6:0]  alpha;
    bit          run_open;
    logic [6:0]  run_index;
    res_t        waiting [$];

    function logic [15:0] palette_color(logic [6:0] idx);
      if (idx == ALPHA_INDEX) idx = alpha;
      return (idx < PAL_SIZE) ? pal_mem[idx] : 16'h0;
    endfunction

    // Apply one accepted word: store a table write, or expand a picture word and queue the runs that it yields.
    function void note_word(logic [1:0] k, logic [6:0] idx, logic [15:0] v);
      logic [7:0] stk [STACK_SIZE];
      int         lvl [STACK_SIZE];
      int         sp;
      bit         stop;
      logic [7:0] b;
      int         depth;
      logic [15:0] pair;
      res_t       runs [$];
      res_t       r;
      if (k == KIND_DICT) begin
        if (idx < DICT_SIZE) dict_mem[idx] = v;
        return;
      end
      if (k == KIND_PAL) begin
        if (idx < PAL_SIZE) pal_mem[idx] = v;
        return;
      end
      if (k != KIND_PIXEL) return;
      stk[0] = v[7:0];
      lvl[0] = 0;
      sp = 1;
      stop = 0;
      while (sp > 0 && !stop) begin
        sp--;
        b = stk[sp];
        depth = lvl[sp];
        r = '0;
        if (b >= CODE_FIRST && b != CODE_END) begin
          pair = (b - CODE_FIRST < DICT_SIZE) ? dict_mem[b - CODE_FIRST] : 16'h0;
          if (depth >= NEST_LIMIT || sp + 2 > STACK_SIZE) begin
            r.nest_error = 1'b1;
            if (runs.size() < MAX_RESULTS) runs.push_back(r);
            stop = 1;
          end else begin
            stk[sp] = pair[7:0];
            lvl[sp] = depth + 1;
            stk[sp + 1] = pair[15:8];
            lvl[sp + 1] = depth + 1;
            sp += 2;
          end
        end else if (b == CODE_END) begin
          run_open = 0;
          r.picture_end = 1'b1;
          if (runs.size() < MAX_RESULTS) runs.push_back(r);
          stop = 1;
        end else if (run_open) begin
          run_open = 0;
          r.color = palette_color(run_index);
          r.run_length = b + 8'd2;
          if (runs.size() < MAX_RESULTS) runs.push_back(r);
        end else if (b & RUN_FLAG) begin
          run_index = b[6:0];
          run_open = 1;
        end else begin
          r.color = palette_color(b[6:0]);
          r.run_length = 8'd1;
          if (runs.size() < MAX_RESULTS) runs.push_back(r);
        end
      end
      if (runs.size() > 0) runs[runs.size() - 1].last = 1'b1;
      foreach (runs[i]) waiting.push_back(runs[i]);
    endfunction

    // Compare one accepted result with the oldest expectation.
    function string check_result(res_t got);
      res_t  want;
      string msg;
      if (waiting.size() == 0)
        return $sformatf("unexpected run color=%h len=%0d", got.color, got.run_length);
      want = waiting.pop_front();
      msg = "";
      if (got.color !== want.color)
        msg = {msg, $sformatf(" color %h/%h", got.color, want.color)};
      if (got.run_length !== want.run_length)
        msg = {msg, $sformatf(" run_length %0d/%0d", got.run_length, want.run_length)};
      if (got.picture_end !== want.picture_end)
        msg = {msg, $sformatf(" picture_end %b/%b", got.picture_end, want.picture_end)};
      if (got.nest_error !== want.nest_error)
        msg = {msg, $sformatf(" nest_error %b/%b", got.nest_error, want.nest_error)};
      if (got.last !== want.last)
        msg = {msg, $sformatf(" last %b/%b", got.last, want.last)};
      return (msg == "") ? "" : {"mismatch (got/expected):", msg};
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic [1:0]  kind;
  logic [6:0]  entry_index;
  logic [15:0] value;
  logic        empty;
  logic        pop;
  logic [15:0] color;
  logic [7:0]  run_length;
  logic        picture_end;
  logic        nest_error;
  logic        last;
  logic        cfg_we;
  logic [6:0]  cfg_data;

  run_scoreboard runs_sb = new();
  int            errors = 0;

  dictionary_rle_palette_decoder DUT (
    .clk(clk), .rst(rst), .push(push), .full(full), .kind(kind),
    .entry_index(entry_index), .value(value), .empty(empty), .pop(pop),
    .color(color), .run_length(run_length), .picture_end(picture_end),
    .nest_error(nest_error), .last(last), .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report(string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // Gap length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Present one word and hold it until the decoder takes it.
  task automatic send_word(logic [1:0] k, logic [6:0] idx, logic [15:0] v);
    int gap;
    push <= 1'b1;
    kind <= k;
    entry_index <= idx;
    value <= v;
    do @(posedge clk); while (full);
    runs_sb.note_word(k, idx, v);
    gap = pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_byte(logic [7:0] b);
    send_word(KIND_PIXEL, 7'($urandom), {8'($urandom), b});
  endtask

  // Stop pushing, let every run drain, then write the alpha register.
  task automatic set_alpha(logic [6:0] a);
    push <= 1'b0;
    while (runs_sb.waiting.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= a;
    runs_sb.alpha = a;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random leaf byte: mostly pixels and run starts, rarely the end marker.
  function automatic logic [7:0] leaf_byte();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 8'($urandom_range(0, PAL_USED - 1));
    if (roll < 97) return 8'($urandom_range(RUN_FLAG, RUN_FLAG + PAL_USED - 1));
    return CODE_END;
  endfunction

  function automatic logic [7:0] any_byte();
    return ($urandom_range(0, 3) == 0)
           ? 8'($urandom_range(CODE_FIRST, CODE_FIRST + DICT_USED - 1))
           : leaf_byte();
  endfunction

  // Random dictionary pair; low entries are leaves so short chains are common.
  task automatic load_entry(int e);
    if (e < DICT_USED / 2)
      send_word(KIND_DICT, 7'(e), {leaf_byte(), leaf_byte()});
    else
      send_word(KIND_DICT, 7'(e), {any_byte(), any_byte()});
  endtask

  // Mixed traffic: mostly picture bytes, some rewrites and ignored words.
  task automatic random_phase(int count);
    int roll;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 78) send_byte(any_byte());
      else if (roll < 86) load_entry($urandom_range(0, DICT_USED - 1));
      else if (roll < 92)
        send_word(KIND_PAL, 7'($urandom), 16'($urandom));
      else if (roll < 96)
        send_word(KIND_DICT, 7'($urandom_range(DICT_SIZE, 127)), 16'($urandom));
      else
        send_word(KIND_NONE, 7'($urandom), 16'($urandom));
    end
  endtask

  // Result side: random stalls, with stretches of steady popping.
  initial begin
    int hold;
    pop <= 1'b0;
    forever begin
      if ($urandom_range(0, 9) < 3) begin
        pop <= 1'b1;
        repeat ($urandom_range(5, 60)) @(posedge clk);
      end else begin
        hold = pick_gap();
        pop <= 1'b0;
        repeat (hold + 1) @(posedge clk);
        pop <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Check every run the decoder hands over.
  always @(posedge clk) begin
    res_t  got;
    string msg;
    if (!rst && pop && !empty) begin
      got = '{color, run_length, picture_end, nest_error, last};
      msg = runs_sb.check_result(got);
      if (msg != "") report(msg);
    end
  end

  // Main sequence.
  initial begin
    rst <= 1'b1;
    push <= 1'b0;
    kind <= KIND_PIXEL;
    entry_index <= '0;
    value <= '0;
    cfg_we <= 1'b0;
    cfg_data <= '0;
    runs_sb.alpha = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Fill every palette and dictionary entry that random leaf bytes and codes
    // can reach, the last palette entry through alpha included.
    for (int p = 0; p < PAL_USED; p++)
      send_word(KIND_PAL, 7'(p), (p == 0) ? 16'h0000 : (p == 1) ? 16'hFFFF
                                                                 : 16'($urandom));
    send_word(KIND_PAL, 7'(PAL_SIZE - 1), 16'($urandom));
    for (int e = 0; e < DICT_USED; e++) load_entry(e);

    // Directed words: field extremes, runs, end marker, codes, deep nesting, ignored writes.
    send_byte(8'h00);
    send_byte(8'h7F);
    send_byte({1'b0, ALPHA_INDEX});
    send_byte(8'h80);
    send_byte(8'h00);
    send_byte(8'h8F);
    send_byte(8'hCF);
    send_byte(8'hC5);
    send_byte(CODE_END);
    send_byte(CODE_END);
    send_word(KIND_DICT, 7'd0, {8'h85, 8'h10});
    send_byte(CODE_FIRST);
    send_word(KIND_DICT, 7'd1, {8'hD0, 8'h22});
    send_byte(CODE_FIRST + 8'd1);
    send_word(KIND_DICT, 7'd2, {8'h84, 8'hFF});
    send_byte(CODE_FIRST + 8'd2);
    send_word(KIND_DICT, 7'd46, {8'hFE, 8'h01});
    send_byte(8'hFE);
    send_word(KIND_DICT, 7'd127, 16'hFFFF);
    send_word(KIND_NONE, 7'h7F, 16'hFFFF);
    send_word(KIND_PAL, 7'd127, 16'hA5A5);
    send_byte(8'h7F);
    send_word(KIND_DICT, 7'd46, {leaf_byte(), leaf_byte()});

    // Random traffic under several alpha settings, extremes included.
    set_alpha(7'h7F);
    send_byte({1'b0, ALPHA_INDEX});
    random_phase(14);
    set_alpha(7'h00);
    random_phase(14);
    set_alpha(7'($urandom_range(0, PAL_USED - 1)));
    random_phase(14);
    set_alpha(ALPHA_INDEX);
    random_phase(14);

    push <= 1'b0;
    while (runs_sb.waiting.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // Watchdog.
  initial begin
    #8_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
